@@ sv/jvmfr_pkg.sv @@
`timescale 1ns / 1ps
package jvmfr_pkg;

	localparam int DEF_STACK_DEPTH  = 64;
	localparam int DEF_LOCALS_DEPTH = 256;

	// opcodes
	localparam logic [3:0] OP_PUSH           = 4'd0;
	localparam logic [3:0] OP_POP            = 4'd1;
	localparam logic [3:0] OP_PEEK           = 4'd2;
	localparam logic [3:0] OP_PUSH_LONG      = 4'd3;
	localparam logic [3:0] OP_POP_LONG       = 4'd4;
	localparam logic [3:0] OP_SET_LOCAL      = 4'd5;
	localparam logic [3:0] OP_GET_LOCAL      = 4'd6;
	localparam logic [3:0] OP_SET_LOCAL_LONG = 4'd7;
	localparam logic [3:0] OP_GET_LOCAL_LONG = 4'd8;

	// result status
	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_OVER   = 2'd1;
	localparam logic [1:0] ST_UNDER  = 2'd2;
	localparam logic [1:0] ST_BADIDX = 2'd3;

	// source of the read data of an item
	localparam logic [1:0] SRC_NONE  = 2'd0;
	localparam logic [1:0] SRC_STACK = 2'd1;
	localparam logic [1:0] SRC_LOCAL = 2'd2;

	// configuration port
	localparam int         CFG_AW        = 3;
	localparam logic       REG_MAX_STACK = 1'b0;
	localparam logic       REG_MAX_LOCAL = 1'b1;

	localparam int MAX_STACK_W = 7;
	localparam int MAX_LOCAL_W = 9;
	localparam int COUNT_W     = 7;

endpackage

@@ sv/jvmfr_ram.sv @@
`timescale 1ns / 1ps
module jvmfr_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ sv/jvm_frame_operand_stack_and_locals_top.sv @@
`timescale 1ns / 1ps
// Result: offered on m_tvalid in the cycle after its item is accepted.
// Throughput: one item per cycle while not stalled; stack and locals each sit in an even
// and an odd bank, so a two-slot access reads or writes both banks in the same cycle.
// Reset: stack pointer zero, stack limit 64, local count 256, output empty.
// Stack and local memories are not cleared; unwritten entries read as garbage.
module jvm_frame_operand_stack_and_locals_top
	import jvmfr_pkg::*;
#(
	parameter int STACK_DEPTH  = DEF_STACK_DEPTH,
	parameter int LOCALS_DEPTH = DEF_LOCALS_DEPTH
) (
	input  logic              clk,
	input  logic              arst_n,
	// s_tdata: opcode[3:0], slot_index[11:4], word_high[43:12], word_low[75:44], zero[79:76]
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [79:0]       s_tdata,
	// m_tdata: status[1:0], read_high[33:2], read_low[65:34], stack_count[72:66],
	// zero[79:73]
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [79:0]       m_tdata,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [CFG_AW-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	localparam int SPW  = $clog2(STACK_DEPTH + 1);
	localparam int CW   = ((SPW > MAX_STACK_W) ? SPW : MAX_STACK_W) + 2;
	localparam int LDW  = $clog2(LOCALS_DEPTH + 1);
	localparam int LCW  = ((LDW > MAX_LOCAL_W) ? LDW : MAX_LOCAL_W) + 1;
	localparam int SBD  = (STACK_DEPTH + 1) / 2;
	localparam int LBD  = (LOCALS_DEPTH + 1) / 2;
	localparam int SAW  = (SBD > 1) ? $clog2(SBD) : 1;
	localparam int LAW  = (LBD > 1) ? $clog2(LBD) : 1;
	localparam int CNTW = (SPW > COUNT_W) ? SPW : COUNT_W;

	// configuration
	logic [MAX_STACK_W-1:0] max_stack_q;
	logic [MAX_LOCAL_W-1:0] max_local_q;
	logic                   cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_stack_q <= MAX_STACK_W'(64);
			max_local_q <= MAX_LOCAL_W'(256);
		end else if (cfg_wr) begin
			case (paddr[2])
				REG_MAX_STACK: max_stack_q <= pwdata[MAX_STACK_W-1:0];
				REG_MAX_LOCAL: max_local_q <= pwdata[MAX_LOCAL_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_MAX_STACK: prdata = {{(32-MAX_STACK_W){1'b0}}, max_stack_q};
			REG_MAX_LOCAL: prdata = {{(32-MAX_LOCAL_W){1'b0}}, max_local_q};
			default:       prdata = '0;
		endcase
	end

	// input fields
	logic [3:0]  op;
	logic [7:0]  idx;
	logic [31:0] word_hi;
	logic [31:0] word_lo;
	logic        acc;

	assign op      = s_tdata[3:0];
	assign idx     = s_tdata[11:4];
	assign word_hi = s_tdata[43:12];
	assign word_lo = s_tdata[75:44];
	assign acc     = s_tvalid && s_tready;

	// control
	logic [SPW-1:0] sp_q;
	logic           out_valid_q;
	logic [1:0]     status_s1;
	logic [COUNT_W-1:0] count_s1;
	logic [1:0]     src_s1;
	logic           dual_s1;
	logic           par_s1;

	// decode
	logic [CW-1:0]  lim;
	logic [CW-1:0]  spx;
	logic [LCW-1:0] nloc;
	logic [LCW-1:0] idxx;
	logic [1:0]     status;
	logic [SPW-1:0] sp_nx;
	logic [SPW-1:0] sf;
	logic           st_we, st_re, lc_we, lc_re, dual;
	logic [31:0]    w0, w1;
	logic [1:0]     src;
	logic [CNTW-1:0] count_x;

	assign lim  = (CW'(max_stack_q) >= CW'(STACK_DEPTH)) ? CW'(STACK_DEPTH)
		: CW'(max_stack_q);
	assign spx  = CW'(sp_q);
	assign nloc = (LCW'(max_local_q) >= LCW'(LOCALS_DEPTH)) ? LCW'(LOCALS_DEPTH)
		: LCW'(max_local_q);
	assign idxx = LCW'(idx);

	always_comb begin
		status = ST_OK;
		sp_nx  = sp_q;
		sf     = sp_q;
		st_we  = 1'b0;
		st_re  = 1'b0;
		lc_we  = 1'b0;
		lc_re  = 1'b0;
		dual   = 1'b0;
		w0     = word_lo;
		w1     = word_lo;
		case (op)
			OP_PUSH: begin
				if (spx >= lim) status = ST_OVER;
				else begin
					st_we = 1'b1;
					sp_nx = SPW'(spx + CW'(1));
				end
			end
			OP_POP: begin
				if (sp_q == '0) status = ST_UNDER;
				else begin
					st_re = 1'b1;
					sf    = SPW'(spx - CW'(1));
					sp_nx = sf;
				end
			end
			OP_PEEK: begin
				if (sp_q == '0) status = ST_UNDER;
				else begin
					st_re = 1'b1;
					sf    = SPW'(spx - CW'(1));
				end
			end
			OP_PUSH_LONG: begin
				if (spx + CW'(2) > lim) status = ST_OVER;
				else begin
					st_we = 1'b1;
					dual  = 1'b1;
					w0    = word_hi;
					sp_nx = SPW'(spx + CW'(2));
				end
			end
			OP_POP_LONG: begin
				if (spx < CW'(2)) status = ST_UNDER;
				else begin
					st_re = 1'b1;
					dual  = 1'b1;
					sf    = SPW'(spx - CW'(2));
					sp_nx = sf;
				end
			end
			OP_SET_LOCAL: begin
				if (idxx >= nloc) status = ST_BADIDX;
				else lc_we = 1'b1;
			end
			OP_GET_LOCAL: begin
				if (idxx >= nloc) status = ST_BADIDX;
				else lc_re = 1'b1;
			end
			OP_SET_LOCAL_LONG: begin
				if (idxx + LCW'(1) >= nloc) status = ST_BADIDX;
				else begin
					lc_we = 1'b1;
					dual  = 1'b1;
					w0    = word_hi;
				end
			end
			OP_GET_LOCAL_LONG: begin
				if (idxx + LCW'(1) >= nloc) status = ST_BADIDX;
				else begin
					lc_re = 1'b1;
					dual  = 1'b1;
				end
			end
			default: ;
		endcase
	end

	always_comb begin
		if (st_re)      src = SRC_STACK;
		else if (lc_re) src = SRC_LOCAL;
		else            src = SRC_NONE;
	end

	assign count_x = CNTW'(sp_nx);

	// banks: entry e lives in bank e[0], row e>>1
	logic [31:0] sd [2];
	logic [31:0] ld [2];

	for (genvar b = 0; b < 2; b++) begin : g_bank
		logic           own_s, own_l;
		logic [SPW-1:0] se;
		logic [8:0]     le;
		logic           s_en, l_en;

		assign own_s = (sf[0] == 1'(b));
		assign own_l = (idx[0] == 1'(b));
		assign se    = own_s ? sf : SPW'(sf + SPW'(1));
		assign le    = own_l ? {1'b0, idx} : 9'({1'b0, idx} + 9'd1);
		assign s_en  = acc && (own_s || dual);
		assign l_en  = acc && (own_l || dual);

		jvmfr_ram #(.WIDTH(32), .DEPTH(SBD)) u_stack (
			.clk  (clk),
			.we   (s_en && st_we),
			.waddr(SAW'(se[SPW-1:1])),
			.wdata(own_s ? w0 : w1),
			.re   (s_en && st_re),
			.raddr(SAW'(se[SPW-1:1])),
			.rdata(sd[b])
		);

		jvmfr_ram #(.WIDTH(32), .DEPTH(LBD)) u_local (
			.clk  (clk),
			.we   (l_en && lc_we),
			.waddr(LAW'(le[8:1])),
			.wdata(own_l ? w0 : w1),
			.re   (l_en && lc_re),
			.raddr(LAW'(le[8:1])),
			.rdata(ld[b])
		);
	end

	// result stage; read data held in the banks while the output stalls
	assign s_tready = !out_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sp_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (acc) begin
				sp_q        <= sp_nx;
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			status_s1 <= status;
			count_s1  <= count_x[COUNT_W-1:0];
			src_s1    <= src;
			dual_s1   <= dual;
			par_s1    <= (src == SRC_LOCAL) ? idx[0] : sf[0];
		end
	end

	logic [31:0] d_par, d_oth, rd_hi, rd_lo;

	always_comb begin
		if (src_s1 == SRC_LOCAL) begin
			d_par = par_s1 ? ld[1] : ld[0];
			d_oth = par_s1 ? ld[0] : ld[1];
		end else begin
			d_par = par_s1 ? sd[1] : sd[0];
			d_oth = par_s1 ? sd[0] : sd[1];
		end
		if (src_s1 == SRC_NONE) begin
			rd_hi = '0;
			rd_lo = '0;
		end else if (dual_s1) begin
			rd_hi = d_par;
			rd_lo = d_oth;
		end else begin
			rd_hi = '0;
			rd_lo = d_par;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {7'd0, count_s1, rd_lo, rd_hi, status_s1};

	// assertions
	a_sp_bound: assert property (@(posedge clk) disable iff (!arst_n)
		CW'(sp_q) <= CW'(STACK_DEPTH))
		else $error("stack pointer beyond stack depth");

	a_stall_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |-> !s_tready)
		else $error("item accepted while result stalled");

	a_err_keeps_sp: assert property (@(posedge clk) disable iff (!arst_n)
		acc && (status != ST_OK) |=> sp_q == $past(sp_q))
		else $error("failed access moved the stack pointer");

	a_err_no_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (status_s1 != ST_OK) |-> (rd_hi == '0) && (rd_lo == '0))
		else $error("failed access returned read data");

endmodule
